/* rtl/assert_macros.svh */
// Assertion macros shared by the deblocker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TVRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TVRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tvrd_pkg.sv */
// Shared types and constants of the tape variable record deblocker.
package tvrd_pkg;

	localparam int unsigned MAX_RESULTS   = 8;
	localparam int unsigned CNT_W         = 4;
	localparam int unsigned IDX_W         = 3;
	localparam int unsigned LEN_W         = 14;
	localparam int unsigned LENGTH_DIGITS = 4;
	localparam int unsigned QDEPTH        = 4;
	localparam int unsigned QPTR_W        = 2;
	localparam int unsigned CMP_W         = 17;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		REG_RECORD_FORMAT = 2'd0,
		REG_FORMS_CONTROL = 2'd1,
		REG_FORCE_BINARY  = 2'd2,
		REG_BLOCK_SIZE    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_BINARY   = 2'd0,
		MODE_TEXT     = 2'd1,
		MODE_FORTRAN  = 2'd2,
		MODE_VARIABLE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_LEN  = 3'b001,
		PH_DATA = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	// One classified item: up to eight result words with their error flags.
	typedef struct packed {
		logic [CNT_W-1:0]            count;
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [MAX_RESULTS-1:0]      err;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/tvrd_front.sv */
// Front end: record parser that classifies each tape word into a result burst.
`include "assert_macros.svh"

module tvrd_front #(
	parameter int unsigned BW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        data_byte,
	input  tvrd_pkg::mode_t   mode,
	input  logic [BW-1:0]     bsz,
	output logic              push,
	output tvrd_pkg::cmd_t    cmd
);

	localparam int unsigned LW = tvrd_pkg::LEN_W;

	tvrd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       digit_q, digit_d;
	logic [LW-1:0]    acc_q, acc_d;
	logic [LW-1:0]    rem_q, rem_d;
	logic [LW-1:0]    rdl_q, rdl_d;
	logic [BW-1:0]    pos_q, pos_d;

	tvrd_pkg::cmd_t   cmd_w;
	logic             err;
	logic [BW:0]      pos_inc;
	logic             block_end;
	logic [BW-1:0]    room;
	logic             is_digit;
	logic [3:0]       dval;
	logic [LW-1:0]    acc10;
	logic [LW-1:0]    rec_len;
	logic             len_short;
	logic             too_long;

	function automatic tvrd_pkg::cmd_t put_word(tvrd_pkg::cmd_t c, logic [7:0] b, logic e);
		tvrd_pkg::cmd_t r;
		r = c;
		if (r.count < tvrd_pkg::CNT_W'(tvrd_pkg::MAX_RESULTS)) begin
			r.bytes[r.count[tvrd_pkg::IDX_W-1:0]] = b;
			r.err[r.count[tvrd_pkg::IDX_W-1:0]]   = e;
			r.count = r.count + tvrd_pkg::CNT_W'(1);
		end
		return r;
	endfunction

	// Four-byte little-endian length frame.
	function automatic tvrd_pkg::cmd_t put_len(tvrd_pkg::cmd_t c, logic [LW-1:0] v);
		tvrd_pkg::cmd_t r;
		r = put_word(c, v[7:0], 1'b0);
		r = put_word(r, 8'(v >> 8), 1'b0);
		r = put_word(r, 8'h00, 1'b0);
		r = put_word(r, 8'h00, 1'b0);
		return r;
	endfunction

	function automatic tvrd_pkg::cmd_t rec_end(tvrd_pkg::cmd_t c, tvrd_pkg::mode_t m,
			logic [LW-1:0] v);
		tvrd_pkg::cmd_t r;
		r = c;
		if (m == tvrd_pkg::MODE_TEXT) begin
			r = put_word(r, tvrd_pkg::CH_LF, 1'b0);
		end else if (m == tvrd_pkg::MODE_VARIABLE) begin
			r = put_len(r, v);
		end
		return r;
	endfunction

	assign pos_inc   = {1'b0, pos_q} + (BW+1)'(1);
	assign block_end = pos_inc >= {1'b0, bsz};
	assign room      = block_end ? '0 : BW'({1'b0, bsz} - pos_inc);
	assign is_digit  = (data_byte >= tvrd_pkg::CH_ZERO) && (data_byte <= tvrd_pkg::CH_NINE);
	assign dval      = 4'(data_byte - tvrd_pkg::CH_ZERO);
	assign acc10     = LW'(acc_q * LW'(10)) + LW'(dval);
	assign len_short = acc10 < LW'(tvrd_pkg::LENGTH_DIGITS);
	assign rec_len   = LW'(acc10 - LW'(tvrd_pkg::LENGTH_DIGITS));
	assign too_long  = tvrd_pkg::CMP_W'(rec_len) > tvrd_pkg::CMP_W'(room);

	always_comb begin
		cmd_w   = '0;
		err     = 1'b0;
		phase_d = phase_q;
		digit_d = digit_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		rdl_d   = rdl_q;
		pos_d   = pos_q;
		if (action) begin
			phase_d = tvrd_pkg::PH_LEN;
			digit_d = '0;
			acc_d   = '0;
			rem_d   = '0;
			rdl_d   = '0;
			pos_d   = '0;
			if (mode == tvrd_pkg::MODE_FORTRAN) begin
				cmd_w = put_word(cmd_w, tvrd_pkg::CH_LF, 1'b0);
			end
		end else if (mode == tvrd_pkg::MODE_BINARY) begin
			cmd_w   = put_word(cmd_w, data_byte, 1'b0);
			phase_d = tvrd_pkg::PH_LEN;
			digit_d = '0;
			acc_d   = '0;
			rem_d   = '0;
			rdl_d   = '0;
			pos_d   = block_end ? '0 : pos_inc[BW-1:0];
		end else begin
			unique case (phase_q)
				tvrd_pkg::PH_LEN: begin
					if (digit_q == '0 && data_byte == tvrd_pkg::CH_CARET) begin
						phase_d = tvrd_pkg::PH_SKIP;
					end else if (!is_digit) begin
						err = 1'b1;
					end else if (digit_q == 2'(tvrd_pkg::LENGTH_DIGITS - 1)) begin
						digit_d = '0;
						acc_d   = '0;
						if (len_short || too_long) begin
							err = 1'b1;
						end else begin
							rdl_d = rec_len;
							rem_d = rec_len;
							if (mode == tvrd_pkg::MODE_VARIABLE) begin
								cmd_w = put_len(cmd_w, rec_len);
							end
							if (rec_len == '0) begin
								if (mode == tvrd_pkg::MODE_FORTRAN) begin
									cmd_w = put_word(cmd_w, tvrd_pkg::CH_LF, 1'b0);
								end
								cmd_w   = rec_end(cmd_w, mode, rec_len);
								phase_d = tvrd_pkg::PH_LEN;
							end else begin
								phase_d = tvrd_pkg::PH_DATA;
							end
						end
					end else begin
						digit_d = digit_q + 2'd1;
						acc_d   = acc10;
					end
				end
				tvrd_pkg::PH_DATA: begin
					if (mode == tvrd_pkg::MODE_FORTRAN && rem_q == rdl_q) begin
						unique case (data_byte)
							tvrd_pkg::CH_ZERO: begin
								cmd_w = put_word(cmd_w, tvrd_pkg::CH_LF, 1'b0);
								cmd_w = put_word(cmd_w, tvrd_pkg::CH_LF, 1'b0);
							end
							tvrd_pkg::CH_PLUS: cmd_w = put_word(cmd_w, tvrd_pkg::CH_CR, 1'b0);
							tvrd_pkg::CH_ONE:  cmd_w = put_word(cmd_w, tvrd_pkg::CH_FF, 1'b0);
							default:           cmd_w = put_word(cmd_w, tvrd_pkg::CH_LF, 1'b0);
						endcase
					end else begin
						cmd_w = put_word(cmd_w, data_byte, 1'b0);
					end
					rem_d = rem_q - LW'(1);
					if (rem_d == '0) begin
						cmd_w   = rec_end(cmd_w, mode, rdl_q);
						phase_d = tvrd_pkg::PH_LEN;
					end
				end
				tvrd_pkg::PH_SKIP: begin
				end
				default: begin
				end
			endcase
			if (err) begin
				cmd_w   = put_word(cmd_w, 8'h00, 1'b1);
				digit_d = '0;
				acc_d   = '0;
				phase_d = tvrd_pkg::PH_SKIP;
			end
			if (block_end) begin
				// a record still open at the block end is flagged once
				if (!err && (phase_d == tvrd_pkg::PH_DATA ||
						(phase_d == tvrd_pkg::PH_LEN && digit_d != '0))) begin
					cmd_w = put_word(cmd_w, 8'h00, 1'b1);
				end
				phase_d = tvrd_pkg::PH_LEN;
				digit_d = '0;
				acc_d   = '0;
				rem_d   = '0;
				rdl_d   = '0;
				pos_d   = '0;
			end else begin
				pos_d = pos_inc[BW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tvrd_pkg::PH_LEN;
			digit_q <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			rdl_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			rdl_q   <= rdl_d;
			pos_q   <= pos_d;
		end
	end

	assign push = accept && (cmd_w.count != '0);
	assign cmd  = cmd_w;

	`TVRD_ASSERT_NEXT(a_binary_holds_parser, clk, arst_n,
		accept && !action && mode == tvrd_pkg::MODE_BINARY,
		phase_q == tvrd_pkg::PH_LEN && digit_q == '0 && acc_q == '0,
		"binary word left the parser out of its reset state")
	`TVRD_ASSERT_NOW(a_single_error_word, clk, arst_n, push, $onehot0(cmd.err),
		"more than one error word in one burst")

endmodule

/* rtl/tvrd_cmd_queue.sv */
// Short queue of classified bursts between the parser and the output stage.
`include "assert_macros.svh"

module tvrd_cmd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tvrd_pkg::cmd_t     wr_cmd,
	input  logic               pop,
	output tvrd_pkg::cmd_t     head,
	output tvrd_pkg::q_stat_t  stat
);

	localparam int unsigned PW = tvrd_pkg::QPTR_W;

	tvrd_pkg::cmd_t  mem_q [tvrd_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == (PW+1)'(tvrd_pkg::QDEPTH);
	assign stat.empty = cnt_q == '0;

	`TVRD_ASSERT_NOW(a_no_push_when_full, clk, arst_n, push, !stat.full,
		"burst written into a full queue")
	`TVRD_ASSERT_NOW(a_no_pop_when_empty, clk, arst_n, pop, !stat.empty,
		"burst taken from an empty queue")

endmodule

/* rtl/tvrd_back.sv */
// Back end: expands queued bursts into single result words behind an output register.
`include "assert_macros.svh"

module tvrd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tvrd_pkg::cmd_t     head,
	input  tvrd_pkg::q_stat_t  q_stat,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               last,
	output logic               format_error
);

	logic [tvrd_pkg::IDX_W-1:0] idx_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;
	logic                       err_q;
	logic                       load;
	logic                       word_last;

	assign load      = !out_valid_q || pop;
	assign word_last = (tvrd_pkg::CNT_W'(idx_q) + tvrd_pkg::CNT_W'(1)) == head.count;
	assign q_pop     = load && !q_stat.empty && word_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			if (!q_stat.empty) begin
				out_valid_q <= 1'b1;
				idx_q       <= word_last ? '0 : idx_q + tvrd_pkg::IDX_W'(1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_stat.empty) begin
			out_byte_q <= head.bytes[idx_q];
			last_q     <= word_last;
			err_q      <= head.err[idx_q];
		end
	end

	assign empty        = !out_valid_q;
	assign out_byte     = out_byte_q;
	assign last         = last_q;
	assign format_error = err_q;

	`TVRD_ASSERT_NEXT(a_idx_rewinds, clk, arst_n, q_pop, idx_q == '0,
		"word index not rewound after the last word of a burst")

endmodule

/* rtl/tape_variable_record_deblocker.sv */
// Top level of the tape variable record deblocker: registers, mode decode, front, queue, back.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  -----------------------------------
//  input     in         push / full            action, data_byte
//  result    out        empty / pop            out_byte, last, format_error
//  config    in         wr_en (no wait)        wr_index, wr_data
//
// One input word is taken per cycle while the burst queue has room; the parser
// turns it into a burst of zero to eight result words in that same cycle.
// The output stage hands out one result word per cycle while pop is held and results wait;
// a result passes through the burst queue and then the output register to the ports.
// Reset clears the parser, block position, queue and output valid, loads defaults.
// Full rises once four bursts wait, behind a stalled result or a long burst.
module tape_variable_record_deblocker #(
	parameter int unsigned BLOCK_MAX = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        format_error,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);

	// block position and effective block size share one width
	localparam int unsigned BW = $clog2(BLOCK_MAX + 1);

	logic [7:0]         record_format_q;
	logic [7:0]         forms_control_q;
	logic               force_binary_q;
	logic [15:0]        block_size_q;

	tvrd_pkg::mode_t    mode;
	logic [BW-1:0]      bsz;
	logic               accept;
	logic               cmd_push;
	tvrd_pkg::cmd_t     cmd;
	tvrd_pkg::cmd_t     head;
	tvrd_pkg::q_stat_t  q_stat;
	logic               q_pop;

	// Configuration registers: the user must write them only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_format_q <= tvrd_pkg::CH_D;
			forms_control_q <= tvrd_pkg::CH_SPACE;
			force_binary_q  <= 1'b0;
			block_size_q    <= 16'd2048;
		end else if (wr_en) begin
			unique case (tvrd_pkg::reg_idx_t'(wr_index))
				tvrd_pkg::REG_RECORD_FORMAT: record_format_q <= wr_data[7:0];
				tvrd_pkg::REG_FORMS_CONTROL: forms_control_q <= wr_data[7:0];
				tvrd_pkg::REG_FORCE_BINARY:  force_binary_q  <= wr_data[0];
				tvrd_pkg::REG_BLOCK_SIZE:    block_size_q    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Decode the output mode from the label characters; anything unknown is binary.
	always_comb begin
		if (force_binary_q || record_format_q != tvrd_pkg::CH_D) begin
			mode = tvrd_pkg::MODE_BINARY;
		end else if (forms_control_q == tvrd_pkg::CH_A) begin
			mode = tvrd_pkg::MODE_FORTRAN;
		end else if (forms_control_q == tvrd_pkg::CH_M) begin
			mode = tvrd_pkg::MODE_VARIABLE;
		end else if (forms_control_q == tvrd_pkg::CH_SPACE) begin
			mode = tvrd_pkg::MODE_TEXT;
		end else begin
			mode = tvrd_pkg::MODE_BINARY;
		end
	end

	// Clamp the block size: zero acts as one, oversize acts as the maximum.
	always_comb begin
		if (block_size_q == '0) begin
			bsz = BW'(1);
		end else if (block_size_q > 16'(BLOCK_MAX)) begin
			bsz = BW'(BLOCK_MAX);
		end else begin
			bsz = BW'(block_size_q);
		end
	end

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	tvrd_front #(
		.BW (BW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.data_byte (data_byte),
		.mode      (mode),
		.bsz       (bsz),
		.push      (cmd_push),
		.cmd       (cmd)
	);

	tvrd_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (cmd),
		.pop    (q_pop),
		.head   (head),
		.stat   (q_stat)
	);

	tvrd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.last         (last),
		.format_error (format_error)
	);

endmodule

/* tb/sv/tb_tape_variable_record_deblocker.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the tape variable record deblocker: directed table, random phases.
module tb_tape_variable_record_deblocker;
	import tvrd_pkg::*;

	// Watchdog: cycles in which no word moves on either side before the run is abandoned.
	// The slowest correct run only pauses for reset, the settle gaps and short random stalls.
	localparam int unsigned STALL_LIMIT   = 4000;
	// Quiet cycles before a register write and at the end.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned RANDOM_WORDS  = 200;
	localparam int unsigned PHASE_WORDS   = 32;
	localparam int unsigned BLOCK_CAP     = 32768;

	// One result word as seen on the output side.
	typedef struct packed {
		logic [7:0] value;
		logic       fin;
		logic       err;
	} result_t;

	typedef enum logic [1:0] {
		ROW_BYTE,
		ROW_EOF,
		ROW_REG
	} row_kind_t;

	// One row of stimulus; typed rows carry the single result word read straight off the spec.
	typedef struct {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [15:0] value;
		bit          typed;
		result_t     want;
	} row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        push         = 1'b0;
	logic        full;
	logic        action       = 1'b0;
	logic [7:0]  data_byte    = 8'h00;
	logic        empty;
	logic        pop          = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        format_error;
	logic        wr_en        = 1'b0;
	logic [1:0]  wr_index     = 2'd0;
	logic [15:0] wr_data      = 16'h0000;

	// Shadow registers of the block.
	logic [7:0]  reg_format;
	logic [7:0]  reg_forms;
	logic        reg_binary;
	logic [15:0] reg_block;

	// Shadow parser state.
	phase_t      rd_phase;
	logic [1:0]  rd_digits;
	logic [13:0] rd_accum;
	logic [13:0] rd_left;
	logic [13:0] rd_size;
	logic [15:0] blk_pos;

	result_t     burst[$];        // results of the word being accepted
	result_t     expected_q[$];   // results still owed by the block
	row_t        plan[$];         // stimulus rows not yet sent

	bit          calm;            // no idling on either side
	bit          busy;            // words sent since the last settle
	int unsigned gen_pos;
	int unsigned gen_span;
	int unsigned gen_made;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned err_words;
	int unsigned reg_writes;
	int unsigned errors;
	int unsigned stall_count;

	tape_variable_record_deblocker #(
		.BLOCK_MAX(BLOCK_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.action(action),
		.data_byte(data_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last(last),
		.format_error(format_error),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic mode_t output_mode();
		if (reg_binary || reg_format != CH_D)
			return MODE_BINARY;
		case (reg_forms)
			CH_A:     return MODE_FORTRAN;
			CH_M:     return MODE_VARIABLE;
			CH_SPACE: return MODE_TEXT;
			default:  return MODE_BINARY;
		endcase
	endfunction

	// Zero behaves as one byte, anything above the cap as the cap.
	function automatic int unsigned block_span(input logic [15:0] size);
		if (size == 16'd0)
			return 1;
		if (size > BLOCK_CAP)
			return BLOCK_CAP;
		return size;
	endfunction

	task automatic parser_clear();
		rd_phase  = PH_LEN;
		rd_digits = 2'd0;
		rd_accum  = 14'd0;
		rd_left   = 14'd0;
		rd_size   = 14'd0;
	endtask

	task automatic pred_reset();
		reg_format = CH_D;
		reg_forms  = CH_SPACE;
		reg_binary = 1'b0;
		reg_block  = 16'd2048;
		parser_clear();
		blk_pos = 16'd0;
	endtask

	task automatic emit(input logic [7:0] v, input logic e);
		if (burst.size() < MAX_RESULTS)
			burst.push_back('{value: v, fin: 1'b0, err: e});
	endtask

	// Little-endian 32-bit length frame of variable mode.
	task automatic emit_length(input logic [13:0] v);
		emit(v[7:0], 1'b0);
		emit({2'b00, v[13:8]}, 1'b0);
		emit(8'h00, 1'b0);
		emit(8'h00, 1'b0);
	endtask

	task automatic close_record(input mode_t m);
		if (m == MODE_TEXT)
			emit(CH_LF, 1'b0);
		else if (m == MODE_VARIABLE)
			emit_length(rd_size);
		rd_phase = PH_LEN;
	endtask

	task automatic open_record(input mode_t m, input logic [13:0] c);
		rd_size = c;
		rd_left = c;
		if (m == MODE_VARIABLE)
			emit_length(c);
		if (c == 14'd0) begin
			// an empty Fortran record still gives its line
			if (m == MODE_FORTRAN)
				emit(CH_LF, 1'b0);
			close_record(m);
		end else begin
			rd_phase = PH_DATA;
		end
	endtask

	task automatic record_byte(input mode_t m, input logic [7:0] b);
		if (m == MODE_FORTRAN && rd_left == rd_size) begin
			// first byte of a Fortran record is carriage control, not data
			case (b)
				CH_ZERO: begin
					emit(CH_LF, 1'b0);
					emit(CH_LF, 1'b0);
				end
				CH_PLUS: emit(CH_CR, 1'b0);
				CH_ONE:  emit(CH_FF, 1'b0);
				default: emit(CH_LF, 1'b0);
			endcase
		end else begin
			emit(b, 1'b0);
		end
		rd_left = rd_left - 14'd1;
		if (rd_left == 14'd0)
			close_record(m);
	endtask

	// Work out the results of one accepted word into burst and advance the shadow state.
	task automatic deblock_word(input logic act, input logic [7:0] b);
		mode_t       m;
		int unsigned bsz;
		int unsigned pos;
		int unsigned len;
		int unsigned room;
		bit          bad;
		bit          open_rec;
		m   = output_mode();
		bsz = block_span(reg_block);
		pos = blk_pos;
		bad = 1'b0;
		burst.delete();
		if (act) begin
			parser_clear();
			blk_pos = 16'd0;
			if (m == MODE_FORTRAN)
				emit(CH_LF, 1'b0);
		end else if (m == MODE_BINARY) begin
			emit(b, 1'b0);
			parser_clear();
			blk_pos = (pos + 1 >= bsz) ? 16'd0 : 16'(pos + 1);
		end else begin
			if (rd_phase == PH_LEN) begin
				if (rd_digits == 2'd0 && b == CH_CARET) begin
					rd_phase = PH_SKIP;
				end else if (b < CH_ZERO || b > CH_NINE) begin
					bad = 1'b1;
				end else begin
					rd_accum = 14'(rd_accum * 10 + (b - CH_ZERO));
					if (rd_digits + 1 >= LENGTH_DIGITS) begin
						len       = rd_accum;
						room      = (pos + 1 < bsz) ? bsz - pos - 1 : 0;
						rd_digits = 2'd0;
						rd_accum  = 14'd0;
						if (len < LENGTH_DIGITS)
							bad = 1'b1;
						else if (len - LENGTH_DIGITS > room)
							bad = 1'b1;
						else
							open_record(m, 14'(len - LENGTH_DIGITS));
					end else begin
						rd_digits = rd_digits + 2'd1;
					end
				end
			end else if (rd_phase == PH_DATA) begin
				record_byte(m, b);
			end
			if (bad) begin
				emit(8'h00, 1'b1);
				rd_digits = 2'd0;
				rd_accum  = 14'd0;
				rd_phase  = PH_SKIP;
			end
			if (pos + 1 >= bsz) begin
				// a record or length still open at the block end is an error too
				open_rec = (rd_phase == PH_DATA) ||
					(rd_phase == PH_LEN && rd_digits != 2'd0);
				if (open_rec && !bad)
					emit(8'h00, 1'b1);
				parser_clear();
				blk_pos = 16'd0;
			end else begin
				blk_pos = 16'(pos + 1);
			end
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].fin = 1'b1;
	endtask

	// ---------------------------------------------------------------- stimulus table

	task automatic plan_row(input row_kind_t kind, input reg_idx_t idx, input logic [15:0] v);
		row_t r;
		r.kind  = kind;
		r.idx   = idx;
		r.value = v;
		r.typed = 1'b0;
		r.want  = '0;
		plan.push_back(r);
	endtask

	task automatic plan_byte(input logic [7:0] b);
		plan_row(ROW_BYTE, REG_RECORD_FORMAT, {8'h00, b});
	endtask

	task automatic plan_eof(input logic [7:0] b);
		plan_row(ROW_EOF, REG_RECORD_FORMAT, {8'h00, b});
	endtask

	task automatic plan_reg(input reg_idx_t idx, input logic [15:0] v);
		plan_row(ROW_REG, idx, v);
	endtask

	task automatic plan_text(input string s);
		for (int i = 0; i < s.len(); i++)
			plan_byte(s[i]);
	endtask

	// Pin the single result word of the last planned row.
	task automatic expect_last(input logic [7:0] v, input logic e);
		plan[plan.size() - 1].typed = 1'b1;
		plan[plan.size() - 1].want  = '{value: v, fin: 1'b1, err: e};
	endtask

	// ---------------------------------------------------------------- random phases

	task automatic put_byte(input logic [7:0] b);
		plan_byte(b);
		gen_pos = (gen_pos + 1 >= gen_span) ? 0 : gen_pos + 1;
		gen_made++;
	endtask

	task automatic put_eof();
		plan_eof(8'($urandom_range(0, 255)));
		gen_pos = 0;
		gen_made++;
	endtask

	task automatic put_length(input int unsigned v);
		put_byte(8'(CH_ZERO + (v / 1000) % 10));
		put_byte(8'(CH_ZERO + (v / 100) % 10));
		put_byte(8'(CH_ZERO + (v / 10) % 10));
		put_byte(8'(CH_ZERO + v % 10));
	endtask

	task automatic put_control();
		case ($urandom_range(0, 4))
			0:       put_byte(CH_SPACE);
			1:       put_byte(CH_ZERO);
			2:       put_byte(CH_PLUS);
			3:       put_byte(CH_ONE);
			default: put_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// Plan one phase: a fresh register setting, then mostly well-formed records that fit
	// the block, with noise, broken lengths, overruns, padding and end-of-file mixed in.
	task automatic plan_phase(input int unsigned idx, input int unsigned quota);
		logic [7:0]  fmt;
		logic [7:0]  forms;
		logic        bin;
		logic [15:0] blk;
		int unsigned r;
		int unsigned room;
		int unsigned lim;
		int unsigned c;
		int unsigned v;
		fmt = ($urandom_range(0, 99) < 85) ? CH_D : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0:       forms = CH_A;
			1:       forms = CH_M;
			2:       forms = CH_SPACE;
			default: forms = 8'($urandom_range(0, 255));
		endcase
		bin = ($urandom_range(0, 99) < 10);
		r   = $urandom_range(0, 99);
		if (r < 5)
			blk = 16'd0;
		else if (r < 10)
			blk = 16'd1;
		else if (r < 14)
			blk = 16'hFFFF;
		else if (r < 18)
			blk = 16'(BLOCK_CAP);
		else if (r < 24)
			blk = 16'd2048;
		else
			blk = 16'($urandom_range(5, 48));
		// make sure the register extremes come round early
		case (idx)
			0: blk = 16'd1;
			1: blk = 16'(BLOCK_CAP);
			2: begin
				fmt   = 8'hFF;
				forms = 8'h00;
			end
			3: begin
				fmt   = 8'h00;
				forms = 8'hFF;
				bin   = 1'b1;
			end
			default: ;
		endcase
		plan_reg(REG_RECORD_FORMAT, {8'h00, fmt});
		plan_reg(REG_FORMS_CONTROL, {8'h00, forms});
		plan_reg(REG_FORCE_BINARY, {15'd0, bin});
		plan_reg(REG_BLOCK_SIZE, blk);
		gen_span = block_span(blk);
		gen_pos  = blk_pos;
		gen_made = 0;
		while (gen_made < quota) begin
			room = (gen_pos < gen_span) ? gen_span - gen_pos : 1;
			r    = $urandom_range(0, 99);
			if (r < 5) begin
				put_eof();
			end else if (r < 10) begin
				put_byte(8'($urandom_range(0, 255)));
			end else if (r < 17) begin
				case ($urandom_range(0, 3))
					0: begin
						// bad digit somewhere in the length
						c = $urandom_range(0, 3);
						for (int i = 0; i < c; i++)
							put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
						do
							v = $urandom_range(0, 255);
						while (v >= CH_ZERO && v <= CH_NINE);
						put_byte(8'(v));
					end
					1: put_length($urandom_range(0, 3));
					2: begin
						v = room + 1 + $urandom_range(0, 5);
						put_length(v > 9999 ? 9999 : v);
					end
					default: begin
						// record cut short by end of file
						c = $urandom_range(2, 6);
						put_length(c + 4);
						for (int i = 0; i < c - 1; i++)
							put_byte(8'($urandom_range(0, 255)));
						put_eof();
					end
				endcase
			end else if (room < 5 || (r < 24 && room < 48)) begin
				// pad out the block
				put_byte(CH_CARET);
				for (int i = 1; i < room; i++)
					put_byte(8'($urandom_range(0, 255)));
			end else begin
				lim = (room - 4 > 10) ? 10 : room - 4;
				c   = $urandom_range(0, lim);
				put_length(c + 4);
				for (int i = 0; i < c; i++) begin
					if (i == 0)
						put_control();
					else
						put_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- driving

	// Hold the input side quiet until every owed result has come, then a little longer.
	task automatic settle();
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		busy = 1'b0;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		case (idx)
			REG_RECORD_FORMAT: reg_format = v[7:0];
			REG_FORMS_CONTROL: reg_forms  = v[7:0];
			REG_FORCE_BINARY:  reg_binary = v[0];
			REG_BLOCK_SIZE:    reg_block  = v;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one word, wait for it to be taken, and book its results.
	task automatic send_word(input row_t r);
		while (!calm && $urandom_range(0, 99) < 9) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		action    <= (r.kind == ROW_EOF);
		data_byte <= r.value[7:0];
		do
			@(posedge clk);
		while (full !== 1'b0);
		words_in++;
		deblock_word(r.kind == ROW_EOF, r.value[7:0]);
		if (r.typed) begin
			expected_q.push_back(r.want);
		end else begin
			foreach (burst[i])
				expected_q.push_back(burst[i]);
		end
		busy = 1'b1;
		@(negedge clk);
	endtask

	task automatic run_plan();
		row_t r;
		while (plan.size() != 0) begin
			r = plan.pop_front();
			if (r.kind == ROW_REG) begin
				if (busy)
					settle();
				write_reg(r.idx, r.value);
			end else begin
				send_word(r);
			end
		end
	endtask

	// Drop pop at random, except through the calm stretch.
	always @(negedge clk) begin
		pop <= arst_n && (calm || $urandom_range(0, 99) >= 9);
	end

	// ---------------------------------------------------------------- checking

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result word: out_byte %02h last %0b format_error %0b",
					out_byte, last, format_error);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (out_byte !== want.value) begin
					$error("out_byte: expected %02h, got %02h", want.value, out_byte);
					errors++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0b, got %0b", want.fin, last);
					errors++;
				end
				if (format_error !== want.err) begin
					$error("format_error: expected %0b, got %0b", want.err, format_error);
					errors++;
				end
				words_out++;
				if (want.err)
					err_words++;
			end
		end
	end

	// Abandon the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("tape_variable_record_deblocker: mismatch");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int unsigned phase_no;
		int unsigned random_words;
		calm         = 1'b0;
		busy         = 1'b0;
		words_in     = 0;
		reg_writes   = 0;
		random_words = 0;
		pred_reset();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Text mode straight out of reset, block of 2048.
		plan_text("0004");
		expect_last(CH_LF, 1'b0);          // empty record, just the newline
		plan_text("x");
		expect_last(8'h00, 1'b1);          // non-digit length byte
		plan_eof(8'hFF);                   // end of file: no word in text mode
		plan_text("0002");
		expect_last(8'h00, 1'b1);          // length under four
		plan_eof(8'h00);
		// Fortran control in a twelve-byte block.
		plan_reg(REG_FORMS_CONTROL, {8'h00, CH_A});
		plan_reg(REG_BLOCK_SIZE, 16'd12);
		plan_text("0006");
		plan_byte(CH_PLUS);                // overprint, then a data byte
		plan_byte(8'hFF);
		plan_text("0004");
		expect_last(CH_LF, 1'b0);          // empty Fortran record
		plan_byte(CH_CARET);               // pad out the last two bytes
		plan_byte(8'h00);
		plan_text("0099");
		expect_last(8'h00, 1'b1);          // record runs past the block end
		plan_eof(8'h00);
		expect_last(CH_LF, 1'b0);          // Fortran end of file gives a newline
		// Variable framing, oversized block register: an empty record makes eight words.
		plan_reg(REG_FORMS_CONTROL, {8'h00, CH_M});
		plan_reg(REG_BLOCK_SIZE, 16'hFFFF);
		plan_text("0004");
		// Forced binary with a zero block size.
		plan_reg(REG_FORCE_BINARY, 16'd1);
		plan_reg(REG_BLOCK_SIZE, 16'd0);
		plan_byte(8'h00);
		expect_last(8'h00, 1'b0);
		plan_byte(8'hFF);
		expect_last(8'hFF, 1'b0);
		plan_eof(8'hFF);
		run_plan();

		// Random phases; the fifth one runs without any idling.
		for (phase_no = 0; random_words < RANDOM_WORDS; phase_no++) begin
			calm = (phase_no == 4);
			plan_phase(phase_no, calm ? 2 * PHASE_WORDS : PHASE_WORDS);
			random_words += gen_made;
			run_plan();
		end
		calm = 1'b0;

		push <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d input words over %0d register writes in %0d phases",
			words_in, reg_writes, phase_no + 1);
		$display("checked %0d result words, %0d of them format errors", words_out, err_words);
		if (errors == 0 && expected_q.size() == 0)
			$display("tape_variable_record_deblocker: match");
		else
			$display("tape_variable_record_deblocker: mismatch");
		$finish;
	end

endmodule
